>>> design/ppp_pkg.sv
// Shared types and constants for the pinhole point projection pipeline.
// No dependencies; imported by every module of the block.
`timescale 1ns / 1ps
`default_nettype none
package ppp_pkg;

   // Field widths
   localparam int WORLD_W = 16;
   localparam int PIX_W   = 24;
   localparam int ROW_W   = 64;
   localparam int DIST_W  = 15;
   localparam int ZOOM_W  = 16;
   localparam int SIZE_W  = 13;

   // Divider geometry: 59-bit magnitude over a positive 32-bit denominator
   localparam int NUM_W      = 59;
   localparam int DEN_W      = 32;
   localparam int QUO_W      = 46;
   localparam int DIV_STAGES = QUO_W;

   // Camera space widths
   localparam int PC_W  = 33;
   localparam int DENS_W = 34;

   // Register indexes of the configuration port
   localparam int CSR_IDX_W = 3;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_X        = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Y        = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_ROW_Z        = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_EYE_DISTANCE = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_ZOOM         = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_WIDTH  = 3'd5;
   localparam logic [CSR_IDX_W-1:0] CSR_PLANE_HEIGHT = 3'd6;

   typedef struct packed {
      logic signed [WORLD_W-1:0] world_x;
      logic signed [WORLD_W-1:0] world_y;
      logic signed [WORLD_W-1:0] world_z;
   } req_type;

   typedef struct packed {
      logic signed [PIX_W-1:0] pixel_x;
      logic signed [PIX_W-1:0] pixel_y;
      logic                    defined;
      logic                    saturated;
   } rsp_type;

   // Camera space point out of the transform stages
   typedef struct packed {
      logic signed [PC_W-1:0]   pcx;
      logic signed [PC_W-1:0]   pcy;
      logic signed [DENS_W-1:0] den;
   } cam_type;

   // Divider result for one axis
   typedef struct packed {
      logic [QUO_W-1:0] quo;
      logic             ovf;
      logic             rem_nz;
   } div_out_type;

   // Per-item flags that ride alongside the dividers
   typedef struct packed {
      logic neg_x;
      logic neg_y;
      logic defined;
   } side_type;

endpackage
`default_nettype wire

>>> design/ppp_xform.sv
// World-to-camera affine transform: input register, products, row sums.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppp_xform (
   input  wire logic                                   clock,
   input  wire logic                                   reset,
   input  wire logic                                   in_valid,
   input  wire ppp_pkg::req_type                       in_point,
   input  wire logic [2:0][ppp_pkg::ROW_W-1:0]         row,
   input  wire logic [ppp_pkg::DIST_W-1:0]             eye_distance,
   output logic                                        out_valid,
   output ppp_pkg::cam_type                            out_cam
);
   import ppp_pkg::*;

   logic                      v0_ff, v1_ff, v2_ff;
   logic signed [WORLD_W-1:0] w_ff [3];
   logic signed [31:0]        prod_ff [3][3];
   logic signed [29:0]        trans_ff [3];
   cam_type                   cam_ff;

   logic signed [31:0]        prod_in [3][3];
   logic signed [29:0]        trans_in [3];
   logic signed [35:0]        sum_in [3];
   cam_type                   cam_in;

   // Coefficient products and translation terms
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         for (int c = 0; c < 3; c++) begin
            prod_in[r][c] = $signed(row[r][16*c +: 16]) * w_ff[c];
         end
         trans_in[r] = 30'($signed(row[r][63:48])) <<< 14;
      end
   end

   // Row sums and eye-relative depth
   always_comb begin
      for (int r = 0; r < 3; r++) begin
         sum_in[r] = 36'(prod_ff[r][0]) + 36'(prod_ff[r][1]) + 36'(prod_ff[r][2])
                   + 36'(trans_ff[r]);
      end
      cam_in.pcx = sum_in[0][PC_W-1:0];
      cam_in.pcy = sum_in[1][PC_W-1:0];
      cam_in.den = DENS_W'(sum_in[2]) + $signed({5'b0, eye_distance, 14'b0});
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         v0_ff <= 1'b0;
         v1_ff <= 1'b0;
         v2_ff <= 1'b0;
      end else begin
         v0_ff <= in_valid;
         v1_ff <= v0_ff;
         v2_ff <= v1_ff;
      end
      w_ff[0]  <= in_point.world_x;
      w_ff[1]  <= in_point.world_y;
      w_ff[2]  <= in_point.world_z;
      prod_ff  <= prod_in;
      trans_ff <= trans_in;
      cam_ff   <= cam_in;
   end

   assign out_valid = v2_ff;
   assign out_cam   = cam_ff;

endmodule
`default_nettype wire

>>> design/ppp_div.sv
// Pipelined restoring divider, one quotient bit per stage, with overflow check.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppp_div (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire logic [ppp_pkg::NUM_W-1:0]     num,
   input  wire logic [ppp_pkg::DEN_W-1:0]     den,
   output logic                               out_valid,
   output ppp_pkg::div_out_type               res
);
   import ppp_pkg::*;

   logic             valid_ff [0:DIV_STAGES];
   logic [DEN_W-1:0] rem_ff   [0:DIV_STAGES];
   logic [DEN_W-1:0] den_ff   [0:DIV_STAGES];
   logic [QUO_W-1:0] lo_ff    [0:DIV_STAGES];
   logic [QUO_W-1:0] quo_ff   [0:DIV_STAGES];
   logic             ovf_ff   [0:DIV_STAGES];

   logic [DEN_W-1:0] top_in;
   logic             ovf_in;

   // Entry: quotient fits QUO_W bits only when the top bits are below den
   assign top_in = DEN_W'(num[NUM_W-1:QUO_W]);
   assign ovf_in = top_in >= den;

   always_ff @(posedge clock) begin
      if (reset) valid_ff[0] <= 1'b0;
      else       valid_ff[0] <= in_valid;
      rem_ff[0] <= ovf_in ? '0 : top_in;
      den_ff[0] <= den;
      lo_ff[0]  <= num[QUO_W-1:0];
      quo_ff[0] <= '0;
      ovf_ff[0] <= ovf_in;
   end

   // One compare and subtract per stage
   for (genvar k = 1; k <= DIV_STAGES; k++) begin : g_stage
      logic [DEN_W:0] trial;
      logic [DEN_W:0] diff;
      logic           ge;

      assign trial = {rem_ff[k-1], lo_ff[k-1][QUO_W-1]};
      assign diff  = trial - {1'b0, den_ff[k-1]};
      assign ge    = trial >= {1'b0, den_ff[k-1]};

      always_ff @(posedge clock) begin
         if (reset) valid_ff[k] <= 1'b0;
         else       valid_ff[k] <= valid_ff[k-1];
         rem_ff[k] <= ge ? diff[DEN_W-1:0] : trial[DEN_W-1:0];
         den_ff[k] <= den_ff[k-1];
         lo_ff[k]  <= {lo_ff[k-1][QUO_W-2:0], 1'b0};
         quo_ff[k] <= {quo_ff[k-1][QUO_W-2:0], ge};
         ovf_ff[k] <= ovf_ff[k-1];
      end
   end

   assign out_valid  = valid_ff[DIV_STAGES];
   assign res.quo    = quo_ff[DIV_STAGES];
   assign res.ovf    = ovf_ff[DIV_STAGES];
   assign res.rem_nz = rem_ff[DIV_STAGES] != '0;

endmodule
`default_nettype wire

>>> design/ppp_scale.sv
// Post-divide scaling: floor fixup, zoom, plane offset and size, saturation.
// Depends on ppp_pkg.
`timescale 1ns / 1ps
`default_nettype none
module ppp_scale (
   input  wire logic                          clock,
   input  wire logic                          reset,
   input  wire logic                          in_valid,
   input  wire ppp_pkg::div_out_type          div_x,
   input  wire ppp_pkg::div_out_type          div_y,
   input  wire ppp_pkg::side_type             side,
   input  wire logic [ppp_pkg::ZOOM_W-1:0]    zoom,
   input  wire logic [ppp_pkg::SIZE_W-1:0]    plane_width,
   input  wire logic [ppp_pkg::SIZE_W-1:0]    plane_height,
   output logic                               out_valid,
   output ppp_pkg::rsp_type                   out_rsp
);
   import ppp_pkg::*;

   localparam logic [QUO_W:0]          QLIM    = 47'h2000_0000_0000;
   localparam logic signed [63:0]      CLIM    = 64'sh10_0000_0000;
   localparam logic signed [37:0]      OFF_X   = 38'sh4_0000;
   localparam logic signed [37:0]      OFF_Y   = 38'sh3_0000;
   localparam logic signed [51:0]      PMAX    = 52'sh7F_FFFF;
   localparam logic signed [51:0]      PMIN    = -52'sh80_0000;
   localparam logic signed [51:0]      T3LIM   = 52'sh180_0000;
   localparam logic [26:0]             RECIP3  = 27'd89478486;
   localparam logic [PIX_W-1:0]        PIX_HI  = 24'h7F_FFFF;
   localparam logic [PIX_W-1:0]        PIX_LO  = 24'h80_0000;

   logic [8:1] v_ff;
   side_type   side_ff [1:7];

   // P1
   logic [QUO_W-1:0] qm_ff [2];
   logic             sat1_ff [2];
   // P2
   logic signed [QUO_W:0] q_ff [2];
   logic             sat2_ff [2];
   // P3
   logic signed [63:0] zp_ff [2];
   logic             sat3_ff [2];
   // P4
   logic signed [37:0] s_ff [2];
   logic             sat4_ff [2];
   // P5
   logic signed [51:0] sp_ff [2];
   logic             sat5_ff [2];
   // P6..P7
   logic [PIX_W-1:0]   px6_ff, px7_ff;
   logic               satx6_ff, satx7_ff;
   logic [25:0]        u6_ff;
   logic               ysat6_ff, yclip6_ff;
   logic [PIX_W-1:0]   yclamp6_ff;
   logic [52:0]        up7_ff;
   logic               ysat7_ff;
   logic               yclip7_ff;
   logic [PIX_W-1:0]   yclamp7_ff;
   rsp_type            rsp_ff;

   div_out_type        d_in [2];
   logic               neg_in [2];
   logic [QUO_W:0]     mag_in [2];
   logic               sat1_in [2];
   logic signed [63:0] cs_in [2];
   logic signed [37:0] c_in [2];
   logic               satc_in [2];
   logic signed [37:0] s_in [2];
   logic [SIZE_W-1:0]  size_in [2];
   logic signed [51:0] tx_in, ty_in;
   logic [PIX_W-1:0]   px_in;
   logic               satx_in;
   logic [51:0]        u_in;
   logic [24:0]        yq_in;
   rsp_type            rsp_in;

   // Floor correction on the quotient magnitude, clamp, zoom and offset
   always_comb begin
      d_in[0]    = div_x;
      d_in[1]    = div_y;
      neg_in[0]  = side.neg_x;
      neg_in[1]  = side.neg_y;
      size_in[0] = plane_width;
      size_in[1] = plane_height;
      for (int a = 0; a < 2; a++) begin
         mag_in[a]  = {1'b0, d_in[a].quo} + (QUO_W+1)'(neg_in[a] & d_in[a].rem_nz);
         sat1_in[a] = d_in[a].ovf | (mag_in[a] > QLIM);
         cs_in[a]   = zp_ff[a] >>> 8;
         satc_in[a] = 1'b0;
         c_in[a]    = cs_in[a][37:0];
         if (cs_in[a] > CLIM) begin
            c_in[a]    = CLIM[37:0];
            satc_in[a] = 1'b1;
         end else if (cs_in[a] < -CLIM) begin
            c_in[a]    = -CLIM[37:0];
            satc_in[a] = 1'b1;
         end
         s_in[a] = c_in[a] + ((a == 0) ? OFF_X : OFF_Y);
      end
   end

   // Final x: shift by 11 and clamp; y: shift by 9, preclamp, then divide by 3
   always_comb begin
      tx_in   = sp_ff[0] >>> 11;
      px_in   = tx_in[PIX_W-1:0];
      satx_in = 1'b0;
      if (tx_in > PMAX) begin
         px_in   = PIX_HI;
         satx_in = 1'b1;
      end else if (tx_in < PMIN) begin
         px_in   = PIX_LO;
         satx_in = 1'b1;
      end
      ty_in = sp_ff[1] >>> 9;
      u_in  = 52'(ty_in + T3LIM);
      yq_in = up7_ff[52:28];
   end

   // Output assembly; undefined points read as zero
   always_comb begin
      rsp_in = '0;
      if (side_ff[7].defined) begin
         rsp_in.pixel_x   = px7_ff;
         rsp_in.pixel_y   = yclip7_ff ? yclamp7_ff : (yq_in[PIX_W-1:0] - PIX_LO);
         rsp_in.defined   = 1'b1;
         rsp_in.saturated = satx7_ff | ysat7_ff;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) v_ff <= '0;
      else       v_ff <= {v_ff[7:1], in_valid};
      side_ff[1] <= side;
      for (int i = 2; i <= 7; i++) side_ff[i] <= side_ff[i-1];
      for (int a = 0; a < 2; a++) begin
         qm_ff[a]   <= sat1_in[a] ? QLIM[QUO_W-1:0] : mag_in[a][QUO_W-1:0];
         sat1_ff[a] <= sat1_in[a];
         q_ff[a]    <= side_ff[1][2-a] ? -$signed({1'b0, qm_ff[a]}) : $signed({1'b0, qm_ff[a]});
         sat2_ff[a] <= sat1_ff[a];
         zp_ff[a]   <= q_ff[a] * $signed({1'b0, zoom});
         sat3_ff[a] <= sat2_ff[a];
         s_ff[a]    <= s_in[a];
         sat4_ff[a] <= sat3_ff[a] | satc_in[a];
         sp_ff[a]   <= s_ff[a] * $signed({1'b0, size_in[a]});
         sat5_ff[a] <= sat4_ff[a];
      end
      px6_ff     <= px_in;
      satx6_ff   <= sat5_ff[0] | satx_in;
      px7_ff     <= px6_ff;
      satx7_ff   <= satx6_ff;
      u6_ff      <= u_in[25:0];
      yclip6_ff  <= (ty_in >= T3LIM) | (ty_in < -T3LIM);
      yclamp6_ff <= (ty_in >= T3LIM) ? PIX_HI : PIX_LO;
      ysat6_ff   <= sat5_ff[1] | (ty_in >= T3LIM) | (ty_in < -T3LIM);
      up7_ff     <= u6_ff * RECIP3;
      yclip7_ff  <= yclip6_ff;
      ysat7_ff   <= ysat6_ff;
      yclamp7_ff <= yclamp6_ff;
      rsp_ff     <= rsp_in;
   end

   assign out_valid = v_ff[8];
   assign out_rsp   = rsp_ff;

endmodule
`default_nettype wire

>>> design/pinhole_point_projection_top.sv
// Top level of the pinhole point projection block: CSRs, numerator stages,
// two dividers and the scaling back end. Depends on ppp_pkg and all ppp_ modules.
//
// Usage:
//  - Input: a beat is taken at a rising edge with start high and busy low.
//    busy is always low, so one world point may enter every cycle.
//  - Output: each result is shown for exactly one cycle with rsp_valid high.
//    The receiver cannot stall; results leave in input order.
//  - Pipeline: a result passes sixty register stages on its way to the
//    rsp_ ports: 3 of transform, 2 of numerator, 47 per divider (overflow
//    check plus one quotient bit per stage for 46 bits) and 8 of scaling.
//    Throughput: one point per cycle.
//  - CSRs: csr_ready is always high; a beat writes register csr_index.
//    Unknown indexes are ignored. Write only while no point is in flight.
//  - Reset (synchronous, active high): flushes all in-flight points and
//    loads identity matrix, eye distance 1.0, zoom 1.0 and a 640x480 plane.
`timescale 1ns / 1ps
`default_nettype none
module pinhole_point_projection_top (
   input  wire logic                              clock,
   input  wire logic                              reset,
   input  wire logic                              start,
   output logic                                   busy,
   input  wire ppp_pkg::req_type                  req_payload,
   output logic                                   rsp_valid,
   output ppp_pkg::rsp_type                       rsp_payload,
   input  wire logic                              csr_valid,
   output logic                                   csr_ready,
   input  wire logic [ppp_pkg::CSR_IDX_W-1:0]     csr_index,
   input  wire logic [ppp_pkg::ROW_W-1:0]         csr_data
);
   import ppp_pkg::*;

   logic [2:0][ROW_W-1:0] row_ff;
   logic [DIST_W-1:0]     dist_ff;
   logic [ZOOM_W-1:0]     zoom_ff;
   logic [SIZE_W-1:0]     width_ff, height_ff;

   logic                  cam_valid;
   cam_type               cam;

   logic                  n_valid_ff, a_valid_ff;
   logic signed [48:0]    nx_ff, ny_ff;
   logic [DEN_W-1:0]      den1_ff, den2_ff;
   logic                  def1_ff;
   logic [NUM_W-1:0]      numx_ff, numy_ff;
   side_type              side2_ff;
   side_type              side_dly_ff [0:DIV_STAGES];

   logic [48:0]           absx_in, absy_in;
   logic                  divx_valid, divy_valid;
   div_out_type           divx, divy;

   assign busy      = 1'b0;
   assign csr_ready = 1'b1;

   // Configuration registers
   always_ff @(posedge clock) begin
      if (reset) begin
         row_ff[0] <= 64'h0000_0000_0000_4000;
         row_ff[1] <= 64'h0000_0000_4000_0000;
         row_ff[2] <= 64'h0000_4000_0000_0000;
         dist_ff   <= 15'd16;
         zoom_ff   <= 16'd256;
         width_ff  <= 13'd640;
         height_ff <= 13'd480;
      end else if (csr_valid) begin
         unique case (csr_index)
            CSR_ROW_X:        row_ff[0] <= csr_data;
            CSR_ROW_Y:        row_ff[1] <= csr_data;
            CSR_ROW_Z:        row_ff[2] <= csr_data;
            CSR_EYE_DISTANCE: dist_ff   <= csr_data[DIST_W-1:0];
            CSR_ZOOM:         zoom_ff   <= csr_data[ZOOM_W-1:0];
            CSR_PLANE_WIDTH:  width_ff  <= csr_data[SIZE_W-1:0];
            CSR_PLANE_HEIGHT: height_ff <= csr_data[SIZE_W-1:0];
            default: ;
         endcase
      end
   end

   ppp_xform u_xform (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (start & ~busy),
      .in_point     (req_payload),
      .row          (row_ff),
      .eye_distance (dist_ff),
      .out_valid    (cam_valid),
      .out_cam      (cam)
   );

   // Numerators pc * d, then magnitudes scaled by 4096
   assign absx_in = nx_ff[48] ? -nx_ff : nx_ff;
   assign absy_in = ny_ff[48] ? -ny_ff : ny_ff;

   always_ff @(posedge clock) begin
      if (reset) begin
         n_valid_ff <= 1'b0;
         a_valid_ff <= 1'b0;
      end else begin
         n_valid_ff <= cam_valid;
         a_valid_ff <= n_valid_ff;
      end
      nx_ff            <= cam.pcx * $signed({1'b0, dist_ff});
      ny_ff            <= cam.pcy * $signed({1'b0, dist_ff});
      den1_ff          <= cam.den[DEN_W-1:0];
      def1_ff          <= cam.den > 0;
      numx_ff          <= {absx_in[46:0], 12'b0};
      numy_ff          <= {absy_in[46:0], 12'b0};
      den2_ff          <= den1_ff;
      side2_ff.neg_x   <= nx_ff[48];
      side2_ff.neg_y   <= ny_ff[48];
      side2_ff.defined <= def1_ff;
   end

   ppp_div u_div_x (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .num       (numx_ff),
      .den       (den2_ff),
      .out_valid (divx_valid),
      .res       (divx)
   );

   ppp_div u_div_y (
      .clock     (clock),
      .reset     (reset),
      .in_valid  (a_valid_ff),
      .num       (numy_ff),
      .den       (den2_ff),
      .out_valid (divy_valid),
      .res       (divy)
   );

   // Sign and defined flags follow the divider latency
   always_ff @(posedge clock) begin
      side_dly_ff[0] <= side2_ff;
      for (int i = 1; i <= DIV_STAGES; i++) side_dly_ff[i] <= side_dly_ff[i-1];
   end

   ppp_scale u_scale (
      .clock        (clock),
      .reset        (reset),
      .in_valid     (divx_valid & divy_valid),
      .div_x        (divx),
      .div_y        (divy),
      .side         (side_dly_ff[DIV_STAGES]),
      .zoom         (zoom_ff),
      .plane_width  (width_ff),
      .plane_height (height_ff),
      .out_valid    (rsp_valid),
      .out_rsp      (rsp_payload)
   );

endmodule
`default_nettype wire
